// ===== src/cbdop_pkg.sv =====
package cbdop_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_DMA   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ROUTE_RAM  = 3'd0,
        ROUTE_PPU  = 3'd1,
        ROUTE_IO   = 3'd2,
        ROUTE_CART = 3'd3,
        ROUTE_PAD  = 3'd4,
        ROUTE_NONE = 3'd5
    } route_t;

    localparam logic [15:0] DMA_START_ADDR = 16'h4014;
    localparam logic [15:0] PAD_ADDR       = 16'h4016;
    localparam logic [7:0]  PAD_TOP_BIT    = 8'h80;

    localparam int DMA_CNT_W  = 9;
    localparam int PPU_RECIP_SHIFT = 24;

    // Decoded item waiting for its work RAM read data
    typedef struct packed {
        route_t      route;
        logic [15:0] addr;
        logic        ppu;
        logic [15:0] ppu_q;
        logic        is_write;
        logic [7:0]  data;
        logic        use_ram;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic        dma_busy;
    } stage_t;

    // Side effects of one item, applied when it is accepted
    typedef struct packed {
        logic ram_we;
        logic ram_re;
        logic pad_load;
        logic pad_shift;
        logic dma_start;
        logic dma_adv;
    } action_t;

endpackage

// ===== src/cbdop_ram.sv =====
module cbdop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/cbdop_decode.sv =====
module cbdop_decode
    import cbdop_pkg::*;
#(
    parameter int RAM_DEPTH  = 2048,
    parameter int RAM_WINDOW = 8192,
    parameter int PPU_WINDOW = 8192,
    parameter int PPU_REGS   = 8,
    parameter int IO_WINDOW  = 32,
    parameter int DMA_LENGTH = 256
) (
    input  logic [1:0]                   cmd,
    input  logic [15:0]                  addr,
    input  logic [7:0]                   wdata,
    input  logic [7:0]                   ext_data,
    input  logic [7:0]                   pad_shift,
    input  logic [7:0]                   dma_page,
    input  logic [DMA_CNT_W-1:0]         dma_count,
    output stage_t                       stage,
    output action_t                      act,
    output logic [$clog2(RAM_DEPTH)-1:0] ram_idx
);

    localparam int RAM_AW  = $clog2(RAM_DEPTH);
    localparam int RQ_BITS = $clog2((RAM_WINDOW - 1) / RAM_DEPTH + 1);
    localparam logic [16:0] RAM_END = 17'(RAM_WINDOW);
    localparam logic [16:0] PPU_END = 17'(RAM_WINDOW + PPU_WINDOW);
    localparam logic [16:0] IO_END  = 17'(RAM_WINDOW + PPU_WINDOW + IO_WINDOW);
    localparam longint unsigned PPU_RECIP = (64'd1 << PPU_RECIP_SHIFT) / PPU_REGS;

    logic [15:0] eff_addr;
    logic [16:0] eff_wide;
    logic        dma_active;
    logic [20:0] rem;
    logic [40:0] ppu_prod;

    assign dma_active = dma_count < DMA_CNT_W'(DMA_LENGTH);
    assign eff_addr   = (cmd == CMD_DMA) ? {dma_page, dma_count[7:0]} : addr;
    assign eff_wide   = {1'b0, eff_addr};

    // Work RAM mirror: restoring reduction, one shifted depth per step
    always_comb begin
        rem = 21'(eff_addr);
        for (int k = RQ_BITS - 1; k >= 0; k--) begin
            if (rem >= (21'(RAM_DEPTH) << k)) begin
                rem = rem - (21'(RAM_DEPTH) << k);
            end
        end
    end

    assign ram_idx = rem[RAM_AW-1:0];

    // Estimated picture register quotient, corrected one stage later
    assign ppu_prod = 41'(eff_addr) * 41'(PPU_RECIP);

    always_comb begin
        stage       = '0;
        stage.route = ROUTE_NONE;
        act         = '0;
        case (cmd)
            CMD_WRITE: begin
                stage.is_write = 1'b1;
                stage.data     = wdata;
                stage.addr     = eff_addr;
                if (eff_wide < RAM_END) begin
                    stage.route = ROUTE_RAM;
                    stage.addr  = 16'(ram_idx);
                    act.ram_we  = 1'b1;
                end else if (eff_wide < PPU_END) begin
                    stage.route = ROUTE_PPU;
                    stage.ppu   = 1'b1;
                    stage.ppu_q = ppu_prod[PPU_RECIP_SHIFT+15:PPU_RECIP_SHIFT];
                end else if (eff_wide < IO_END) begin
                    if (eff_addr == DMA_START_ADDR) begin
                        stage.route   = ROUTE_NONE;
                        act.dma_start = 1'b1;
                    end else if (eff_addr == PAD_ADDR) begin
                        stage.route  = ROUTE_PAD;
                        act.pad_load = 1'b1;
                    end else begin
                        stage.route = ROUTE_IO;
                    end
                end else begin
                    stage.route = ROUTE_CART;
                end
            end
            CMD_READ, CMD_DMA: begin
                if (cmd == CMD_READ || dma_active) begin
                    stage.addr = eff_addr;
                    stage.data = ext_data;
                    if (eff_wide < RAM_END) begin
                        stage.route   = ROUTE_RAM;
                        stage.addr    = 16'(ram_idx);
                        stage.use_ram = 1'b1;
                        act.ram_re    = 1'b1;
                    end else if (eff_wide < PPU_END) begin
                        stage.route = ROUTE_PPU;
                        stage.ppu   = 1'b1;
                        stage.ppu_q = ppu_prod[PPU_RECIP_SHIFT+15:PPU_RECIP_SHIFT];
                    end else if (eff_wide < IO_END && eff_addr == PAD_ADDR) begin
                        stage.route   = ROUTE_PAD;
                        stage.data    = {7'd0, |(pad_shift & PAD_TOP_BIT)};
                        act.pad_shift = 1'b1;
                    end else if (eff_wide < IO_END) begin
                        stage.route = ROUTE_IO;
                    end else begin
                        stage.route = ROUTE_CART;
                    end
                    if (cmd == CMD_DMA) begin
                        stage.oam_write = 1'b1;
                        stage.oam_index = dma_count[7:0];
                        stage.dma_busy  = 1'b1;
                        act.dma_adv     = 1'b1;
                    end
                end
            end
            default: begin
                stage.route = ROUTE_NONE;
            end
        endcase
    end

endmodule

// ===== src/cpu_bus_decode_oam_dma_pad_port_unit.sv =====
// CPU bus decoder with mirrored work RAM, sprite-page DMA and one pad port.
// One item per clock is accepted while the decode stage can move on; each
// gives exactly one result, via the registered work RAM read and the decode
// stage register, then the output register. The decode stage holds an item
// while the output is stalled, so one new item is still taken while a result
// waits. Work RAM contents are undefined after reset; the pad shift register,
// DMA page and DMA count (idle) are reset, with no clearing pass.
module cpu_bus_decode_oam_dma_pad_port_unit
    import cbdop_pkg::*;
#(
    parameter int RAM_DEPTH  = 2048,
    parameter int RAM_WINDOW = 8192,
    parameter int PPU_WINDOW = 8192,
    parameter int PPU_REGS   = 8,
    parameter int IO_WINDOW  = 32,
    parameter int DMA_LENGTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // addr[15:0], wdata[23:16], buttons[31:24], ext_data[39:32]
    input  logic [39:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // route_addr[15:0], is_write[16], out_data[24:17], oam_write[25],
    // oam_index[33:26], dma_busy[34], zero[39:35]
    output logic [39:0] m_tdata,
    // route[2:0]
    output logic [2:0]  m_tuser
);

    localparam int RAM_AW = $clog2(RAM_DEPTH);

    logic [15:0] in_addr;
    logic [7:0]  in_wdata;
    logic [7:0]  in_buttons;
    logic [7:0]  in_ext;

    logic                 s_accept;
    logic                 s1_move;
    stage_t               dec_stage;
    action_t              dec_act;
    logic [RAM_AW-1:0]    ram_idx;
    logic [7:0]           ram_rdata;

    logic                 s1_valid_reg, s1_valid_next;
    stage_t               s1_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [39:0]          m_data_reg;
    logic [2:0]           m_user_reg;

    logic [7:0]           pad_reg, pad_next;
    logic [7:0]           page_reg, page_next;
    logic [DMA_CNT_W-1:0] count_reg, count_next;

    logic [22:0]          ppu_prod;
    logic [15:0]          ppu_rem;
    logic [15:0]          out_addr;
    logic [7:0]           out_data;

    assign in_addr    = s_tdata[15:0];
    assign in_wdata   = s_tdata[23:16];
    assign in_buttons = s_tdata[31:24];
    assign in_ext     = s_tdata[39:32];

    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_tready);
    // Take no item while reset is held
    assign s_tready = aresetn && (!s1_valid_reg || s1_move);
    assign s_accept = s_tvalid && s_tready;

    cbdop_decode #(
        .RAM_DEPTH (RAM_DEPTH),
        .RAM_WINDOW(RAM_WINDOW),
        .PPU_WINDOW(PPU_WINDOW),
        .PPU_REGS  (PPU_REGS),
        .IO_WINDOW (IO_WINDOW),
        .DMA_LENGTH(DMA_LENGTH)
    ) u_decode (
        .cmd      (s_tuser),
        .addr     (in_addr),
        .wdata    (in_wdata),
        .ext_data (in_ext),
        .pad_shift(pad_reg),
        .dma_page (page_reg),
        .dma_count(count_reg),
        .stage    (dec_stage),
        .act      (dec_act),
        .ram_idx  (ram_idx)
    );

    // Read only on accept, so the read data holds while the item is stalled
    cbdop_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_work_ram (
        .aclk (aclk),
        .we   (s_accept && dec_act.ram_we),
        .waddr(ram_idx),
        .wdata(in_wdata),
        .re   (s_accept && dec_act.ram_re),
        .raddr(ram_idx),
        .rdata(ram_rdata)
    );

    always_comb begin
        pad_next   = pad_reg;
        page_next  = page_reg;
        count_next = count_reg;
        if (s_accept) begin
            if (dec_act.pad_load) begin
                pad_next = in_buttons;
            end else if (dec_act.pad_shift) begin
                pad_next = {pad_reg[6:0], 1'b0};
            end
            if (dec_act.dma_start) begin
                page_next  = in_wdata;
                count_next = '0;
            end else if (dec_act.dma_adv) begin
                count_next = count_reg + DMA_CNT_W'(1);
            end
        end
    end

    // Finish the picture register remainder from the estimated quotient
    always_comb begin
        ppu_prod = 23'(s1_reg.ppu_q) * 23'(PPU_REGS);
        ppu_rem  = s1_reg.addr - ppu_prod[15:0];
        if (ppu_rem >= 16'(PPU_REGS)) begin
            ppu_rem = ppu_rem - 16'(PPU_REGS);
        end
        out_addr = s1_reg.ppu ? ppu_rem : s1_reg.addr;
        out_data = s1_reg.use_ram ? ram_rdata : s1_reg.data;
    end

    assign s1_valid_next = s_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = s1_move ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pad_reg      <= '0;
            page_reg     <= '0;
            count_reg    <= DMA_CNT_W'(DMA_LENGTH);
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            pad_reg      <= pad_next;
            page_reg     <= page_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg <= dec_stage;
        end
        if (s1_move) begin
            m_data_reg <= {5'd0, s1_reg.dma_busy, s1_reg.oam_index, s1_reg.oam_write,
                           out_data, s1_reg.is_write, out_addr};
            m_user_reg <= s1_reg.route;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DMA_CNT_W'(DMA_LENGTH))
        else $error("dma count beyond copy length");

    a_stall_holds_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_move) |-> !(s_accept && dec_act.ram_re))
        else $error("ram read issued while decoded item is stalled");

    a_busy_means_oam: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[34]) |-> (m_data_reg[25] && !m_data_reg[16]))
        else $error("dma busy result without sprite write");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without output back-pressure");

    a_dma_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && dec_act.dma_adv) |=> (count_reg == $past(count_reg) + DMA_CNT_W'(1)))
        else $error("dma count did not advance on a tick");
`endif

endmodule

// ===== verif/tb_cpu_bus_decode_oam_dma_pad_port_unit.sv =====
`timescale 1ns / 100ps

module tb_cpu_bus_decode_oam_dma_pad_port_unit;
    import cbdop_pkg::*;

    localparam logic [1:0]  CMD_SPARE    = 2'd3;
    localparam logic [15:0] RAM_END      = 16'h2000;
    localparam logic [15:0] PPU_END      = 16'h4000;
    localparam logic [15:0] IO_END       = 16'h4020;
    localparam logic [8:0]  DMA_LEN      = 9'd256;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          HOLD_AFTER   = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    typedef struct packed {
        route_t      route;
        logic [15:0] raddr;
        logic        wr;
        logic [7:0]  data;
        logic        oam_wr;
        logic [7:0]  oam_idx;
        logic        busy;
    } bus_result_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  buttons;
        logic [7:0]  ext;
        logic        fixed;
        bus_result_t want;
    } bus_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    // Shadow of the bus state, advanced once per accepted item
    logic [7:0]  ram_copy [0:2047];
    bit          ram_written [0:2047];
    logic [7:0]  pad_bits = 8'h00;
    logic [7:0]  dma_pg   = 8'h00;
    logic [8:0]  dma_cnt  = DMA_LEN;

    bus_result_t pending_results [$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          stim_items   = 0;
    int          burst_left   = 0;
    int unsigned cycle_cnt    = 0;

    cpu_bus_decode_oam_dma_pad_port_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bus_result_t bus_res(input route_t route, input logic [15:0] raddr,
                                            input logic wr, input logic [7:0] data);
        return '{route, raddr, wr, data, 1'b0, 8'h00, 1'b0};
    endfunction

    function automatic bus_result_t decode_read(input logic [15:0] a, input logic [7:0] ext);
        bus_result_t r;
        if (a < RAM_END) begin
            r = bus_res(ROUTE_RAM, {5'd0, a[10:0]}, 1'b0, ram_copy[a[10:0]]);
        end else if (a < PPU_END) begin
            r = bus_res(ROUTE_PPU, {13'd0, a[2:0]}, 1'b0, ext);
        end else if (a == PAD_ADDR) begin
            // hand back the top bit, then shift towards it with zero fill
            r = bus_res(ROUTE_PAD, a, 1'b0, {7'd0, pad_bits[7]});
            pad_bits = {pad_bits[6:0], 1'b0};
        end else if (a < IO_END) begin
            r = bus_res(ROUTE_IO, a, 1'b0, ext);
        end else begin
            r = bus_res(ROUTE_CART, a, 1'b0, ext);
        end
        return r;
    endfunction

    function automatic bus_result_t decode_bus_item(input logic [1:0] cmd, input logic [15:0] a,
                                                    input logic [7:0] wd, input logic [7:0] btn,
                                                    input logic [7:0] ext);
        bus_result_t r;
        r = bus_res(ROUTE_NONE, 16'h0000, 1'b0, 8'h00);
        case (cmd)
            CMD_READ: begin
                r = decode_read(a, ext);
            end
            CMD_WRITE: begin
                if (a < RAM_END) begin
                    ram_copy[a[10:0]]    = wd;
                    ram_written[a[10:0]] = 1'b1;
                    r = bus_res(ROUTE_RAM, {5'd0, a[10:0]}, 1'b1, wd);
                end else if (a < PPU_END) begin
                    r = bus_res(ROUTE_PPU, {13'd0, a[2:0]}, 1'b1, wd);
                end else if (a == DMA_START_ADDR) begin
                    // restart the page copy from its first byte
                    dma_pg  = wd;
                    dma_cnt = '0;
                    r = bus_res(ROUTE_NONE, a, 1'b1, wd);
                end else if (a == PAD_ADDR) begin
                    pad_bits = btn;
                    r = bus_res(ROUTE_PAD, a, 1'b1, wd);
                end else if (a < IO_END) begin
                    r = bus_res(ROUTE_IO, a, 1'b1, wd);
                end else begin
                    r = bus_res(ROUTE_CART, a, 1'b1, wd);
                end
            end
            CMD_DMA: begin
                if (dma_cnt < DMA_LEN) begin
                    r = decode_read({dma_pg, dma_cnt[7:0]}, ext);
                    r.oam_wr  = 1'b1;
                    r.oam_idx = dma_cnt[7:0];
                    r.busy    = 1'b1;
                    dma_cnt   = dma_cnt + 9'd1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_bus_item(input logic [1:0] cmd, input logic [15:0] a,
                                 input logic [7:0] wd, input logic [7:0] btn,
                                 input logic [7:0] ext, input logic fixed,
                                 input bus_result_t want);
        bus_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ext, btn, wd, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // idle ticks and the spare command do not count towards the run
        if (cmd != CMD_SPARE && !(cmd == CMD_DMA && dma_cnt >= DMA_LEN))
            stim_items++;
        predicted = decode_bus_item(cmd, a, wd, btn, ext);
        pending_results.push_back(fixed ? want : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
    endtask

    function automatic logic [1:0] rand_rw();
        return ($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ;
    endfunction

    function automatic logic [15:0] rand_addr();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)      return 16'($urandom_range(0, 16'h1FFF));
        else if (sel < 50) return 16'($urandom_range(16'h2000, 16'h3FFF));
        else if (sel < 55) return PAD_ADDR;
        else if (sel < 58) return DMA_START_ADDR;
        else if (sel < 70) return 16'($urandom_range(16'h4000, 16'h401F));
        else               return 16'($urandom_range(16'h4020, 16'hFFFF));
    endfunction

    task automatic send_access(input logic [1:0] cmd, input logic [15:0] a);
        // never read a work RAM byte that has not been written: write it instead
        if (cmd == CMD_READ && a < RAM_END && !ram_written[a[10:0]])
            cmd = CMD_WRITE;
        send_bus_item(cmd, a, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    task automatic send_dma_tick();
        logic [15:0] src;
        src = {dma_pg, dma_cnt[7:0]};
        if (dma_cnt < DMA_LEN && src < RAM_END && !ram_written[src[10:0]])
            send_bus_item(CMD_WRITE, {3'd0, 2'($urandom), src[10:0]}, 8'($urandom),
                          8'($urandom), 8'($urandom), 1'b0, '0);
        send_bus_item(CMD_DMA, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'b0, '0);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        bus_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result expected none got route %0d tdata %h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("route", 16'(want.route), 16'(m_tuser));
                check_field("route_addr", want.raddr, m_tdata[15:0]);
                check_field("is_write", 16'(want.wr), 16'(m_tdata[16]));
                check_field("out_data", 16'(want.data), 16'(m_tdata[24:17]));
                check_field("oam_write", 16'(want.oam_wr), 16'(m_tdata[25]));
                check_field("oam_index", 16'(want.oam_idx), 16'(m_tdata[33:26]));
                check_field("dma_busy", 16'(want.busy), 16'(m_tdata[34]));
                check_field("tdata fill", 16'h0000, 16'(m_tdata[39:35]));
            end
        end
    end

    initial begin : sink_pacing
        int         mode;
        int         len;
        int         k;
        logic [7:0] mask;
        bit         held;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                // hold off long enough for the block to fill and stall its input
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(16, 160);
                mask = 8'($urandom) | 8'h01;
                for (k = 0; k < len; k++) begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom);
                        2:       m_tready <= mask[k[2:0]];
                        default: m_tready <= ($urandom_range(0, 9) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin : watchdog
        wait (cycle_cnt == CYCLE_LIMIT);
        $display("tb_cpu_bus_decode_oam_dma_pad_port_unit: errors");
        $finish;
    end

    initial begin : stimulus
        bus_row_t   dir_rows [$];
        int         n;
        int         sel;
        logic [7:0] page;

        dir_rows.push_back('{CMD_DMA, 16'h0000, 8'h5A, 8'hFF, 8'hC3, 1'b1,
                             bus_res(ROUTE_NONE, 16'h0000, 1'b0, 8'h00)});
        dir_rows.push_back('{CMD_SPARE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                             bus_res(ROUTE_NONE, 16'h0000, 1'b0, 8'h00)});
        dir_rows.push_back('{CMD_READ, PAD_ADDR, 8'h00, 8'hFF, 8'hFF, 1'b1,
                             bus_res(ROUTE_PAD, PAD_ADDR, 1'b0, 8'h00)});
        dir_rows.push_back('{CMD_WRITE, 16'h0000, 8'hFF, 8'h00, 8'h00, 1'b1,
                             bus_res(ROUTE_RAM, 16'h0000, 1'b1, 8'hFF)});
        dir_rows.push_back('{CMD_WRITE, 16'h1FFF, 8'h00, 8'hFF, 8'hFF, 1'b1,
                             bus_res(ROUTE_RAM, 16'h07FF, 1'b1, 8'h00)});
        dir_rows.push_back('{CMD_READ, 16'h0800, 8'h00, 8'h00, 8'h77, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 16'h17FF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0});
        dir_rows.push_back('{CMD_WRITE, 16'h2000, 8'h81, 8'h00, 8'h00, 1'b1,
                             bus_res(ROUTE_PPU, 16'h0000, 1'b1, 8'h81)});
        dir_rows.push_back('{CMD_READ, 16'h3FFF, 8'h00, 8'h00, 8'hA5, 1'b1,
                             bus_res(ROUTE_PPU, 16'h0007, 1'b0, 8'hA5)});
        dir_rows.push_back('{CMD_WRITE, 16'h4000, 8'h42, 8'h00, 8'h00, 1'b1,
                             bus_res(ROUTE_IO, 16'h4000, 1'b1, 8'h42)});
        dir_rows.push_back('{CMD_READ, DMA_START_ADDR, 8'h00, 8'h00, 8'h5A, 1'b1,
                             bus_res(ROUTE_IO, DMA_START_ADDR, 1'b0, 8'h5A)});
        dir_rows.push_back('{CMD_READ, 16'h401F, 8'h00, 8'h00, 8'h3C, 1'b1,
                             bus_res(ROUTE_IO, 16'h401F, 1'b0, 8'h3C)});
        dir_rows.push_back('{CMD_WRITE, 16'h4020, 8'h99, 8'h00, 8'h00, 1'b1,
                             bus_res(ROUTE_CART, 16'h4020, 1'b1, 8'h99)});
        dir_rows.push_back('{CMD_READ, 16'hFFFF, 8'h00, 8'h00, 8'hFF, 1'b1,
                             bus_res(ROUTE_CART, 16'hFFFF, 1'b0, 8'hFF)});
        dir_rows.push_back('{CMD_WRITE, PAD_ADDR, 8'h3C, 8'hA5, 8'h00, 1'b1,
                             bus_res(ROUTE_PAD, PAD_ADDR, 1'b1, 8'h3C)});
        dir_rows.push_back('{CMD_READ, PAD_ADDR, 8'h00, 8'h00, 8'h00, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, PAD_ADDR, 8'hFF, 8'h00, 8'hFF, 1'b0, '0});
        dir_rows.push_back('{CMD_WRITE, DMA_START_ADDR, 8'h00, 8'hFF, 8'hFF, 1'b1,
                             bus_res(ROUTE_NONE, DMA_START_ADDR, 1'b1, 8'h00)});
        dir_rows.push_back('{CMD_DMA, 16'hFFFF, 8'hFF, 8'hFF, 8'h12, 1'b0, '0});
        dir_rows.push_back('{CMD_READ, 16'h8000, 8'h00, 8'h00, 8'h11, 1'b0, '0});
        dir_rows.push_back('{CMD_WRITE, DMA_START_ADDR, 8'hFF, 8'h00, 8'h00, 1'b1,
                             bus_res(ROUTE_NONE, DMA_START_ADDR, 1'b1, 8'hFF)});
        dir_rows.push_back('{CMD_DMA, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, '0});
        dir_rows.push_back('{CMD_DMA, 16'h0000, 8'h00, 8'h00, 8'hFF, 1'b0, '0});
        dir_rows.push_back('{CMD_SPARE, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1,
                             bus_res(ROUTE_NONE, 16'h0000, 1'b0, 8'h00)});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        burst_left = $urandom_range(1, 30);

        foreach (dir_rows[i])
            send_bus_item(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].wdata,
                          dir_rows[i].buttons, dir_rows[i].ext, dir_rows[i].fixed,
                          dir_rows[i].want);

        stim_items = 0;
        while (stim_items < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                repeat ($urandom_range(1, 8)) send_access(rand_rw(), rand_addr());
            end else if (sel < 50) begin
                // load the pad, then clock it out, at times past its eighth bit
                send_bus_item(CMD_WRITE, PAD_ADDR, 8'($urandom), 8'($urandom),
                              8'($urandom), 1'b0, '0);
                n = $urandom_range(1, 10);
                repeat (n) begin
                    if ($urandom_range(0, 5) == 0) send_access(rand_rw(), rand_addr());
                    send_access(CMD_READ, PAD_ADDR);
                end
            end else if (sel < 85) begin
                sel  = $urandom_range(0, 9);
                page = (sel < 4) ? 8'($urandom_range(0, 8'h1F)) :
                       (sel < 5) ? 8'($urandom_range(8'h20, 8'h3F)) :
                       (sel < 6) ? 8'h40 : 8'($urandom);
                send_bus_item(CMD_WRITE, DMA_START_ADDR, page, 8'($urandom),
                              8'($urandom), 1'b0, '0);
                // now and then run the copy to its end, at times ticking past it
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 262)
                                                : $urandom_range(1, 40);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) send_access(rand_rw(), rand_addr());
                    send_dma_tick();
                end
            end else if ($urandom_range(0, 1) != 0) begin
                send_bus_item(CMD_SPARE, 16'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 1'b0, '0);
            end else begin
                send_dma_tick();
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_cpu_bus_decode_oam_dma_pad_port_unit: clean");
        else
            $display("tb_cpu_bus_decode_oam_dma_pad_port_unit: errors");
        $finish;
    end

endmodule
